### rtl/dagr_pkg.sv
// Shared types, opcodes and constants for the DAG reachability engine.
`default_nettype none

package dagr_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int VERTEX_W         = 9;
  localparam int OPCODE_W         = 3;
  localparam int PAIR_W           = 16;

  localparam logic [VERTEX_W-1:0] VC_RESET = 9'd256;
  localparam logic [PAIR_W-1:0]   PAIR_MAX = 16'hFFFF;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FULL   = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
  } in_word_t;

  typedef struct packed {
    logic              answer_kind;
    logic              reachable;
    logic [PAIR_W-1:0] pair_count;
  } out_word_t;

  // Controls of the row OR accumulator.
  typedef struct packed {
    logic load;
    logic step;
    logic self_j;
  } row_or_ctl_t;

  // Controls of the population counter.
  typedef struct packed {
    logic clear_total;
    logic load;
    logic step;
  } popcnt_ctl_t;

endpackage

`default_nettype wire

### rtl/dagr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dagr_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/dagr_row_or.sv
// Row OR accumulator: walks an adjacency row bit by bit and ORs in successor rows.
`default_nettype none

module dagr_row_or #(
  parameter int Width = 256
) (
  input  wire logic                  clk,
  input  wire dagr_pkg::row_or_ctl_t ctl,
  input  wire logic [Width-1:0]      adj_row,
  input  wire logic [Width-1:0]      reach_rd,
  output logic      [Width-1:0]      acc_or
);

  logic [Width-1:0] adj_sh_r;
  logic [Width-1:0] acc_r;
  logic             flag_r;

  // The flag marks that the read issued in the previous cycle belongs to a successor.
  assign acc_or = acc_r | (flag_r ? reach_rd : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      adj_sh_r <= adj_row;
      acc_r    <= '0;
      flag_r   <= 1'b0;
    end else if (ctl.step) begin
      adj_sh_r <= adj_sh_r >> 1;
      acc_r    <= acc_or;
      flag_r   <= adj_sh_r[0] & ~ctl.self_j;
    end
  end

endmodule

`default_nettype wire

### rtl/dagr_popcnt.sv
// Population counter: adds the set bits of a row one byte per cycle, while ctl.step is high, into a running total.
`default_nettype none

module dagr_popcnt #(
  parameter int Width = 256
) (
  input  wire logic                                 clk,
  input  wire dagr_pkg::popcnt_ctl_t                ctl,
  input  wire logic [Width-1:0]                     row,
  output logic      [$clog2(Width*Width+1)-1:0]     total,
  output logic                                      last
);

  localparam int Chunks = (Width + 7) / 8;
  localparam int SW     = Chunks * 8;
  localparam int TW     = $clog2(Width * Width + 1);
  localparam int CHW    = (Chunks > 1) ? $clog2(Chunks) : 1;

  logic [SW-1:0]  sh_r;
  logic [CHW-1:0] chunk_r;
  logic [TW-1:0]  total_r;
  logic [3:0]     byte_cnt;

  always_comb begin
    byte_cnt = '0;
    for (int k = 0; k < 8; k++) begin
      byte_cnt = byte_cnt + {3'd0, sh_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_total) begin
      total_r <= '0;
    end else if (ctl.step) begin
      total_r <= total_r + TW'(byte_cnt);
    end
    if (ctl.load) begin
      sh_r    <= SW'(row);
      chunk_r <= '0;
    end else if (ctl.step) begin
      sh_r    <= sh_r >> 8;
      chunk_r <= chunk_r + CHW'(1);
    end
  end

  assign total = total_r;
  assign last  = (chunk_r == CHW'(Chunks - 1));

endmodule

`default_nettype wire

### rtl/dag_reachability_bitset_engine.sv
// Top level of the DAG reachability engine: sequencer, matrix stores and result register.
//
//  Channel | Direction | Handshake         | Word
//  --------+-----------+-------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall | opcode, src_vertex, dst_vertex
//  out_    | output    | out_valid/out_stall | answer_kind, reachable, pair_count
//  cfg_    | input     | cfg_valid/cfg_ready | vertex_count (9 bits)
//
// One word is worked on at a time; in_stall is high from acceptance until the word is
// done and any result has been handed to the output register. A rebuild reads one
// successor row per cycle through the single read port of the reach store, and rows
// are counted through the byte-wide popcount unit (N = MAX_VERTICES).
// After reset a clearing pass zeroes both stores, one row a cycle, while no input
// word is taken. The output register lets a new word be accepted while the previous
// result still waits under out_stall.
`default_nettype none

module dag_reachability_bitset_engine #(
  parameter int MAX_VERTICES = dagr_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire dagr_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dagr_pkg::out_word_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dagr_pkg::VERTEX_W-1:0]   cfg_data
);

  // Vertex numbers run 1..N; row v and bit v live at address and bit v-1.
  localparam int N   = MAX_VERTICES;
  localparam int VW  = $clog2(N + 1);
  localparam int AW  = $clog2(N);
  localparam int CW  = (VW > dagr_pkg::VERTEX_W) ? VW : dagr_pkg::VERTEX_W;
  localparam int TW  = $clog2(N * N + 1);
  localparam int EW  = (TW > dagr_pkg::PAIR_W) ? TW : dagr_pkg::PAIR_W + 1;

  localparam logic [4:0] ST_CLEAR     = 5'd0;
  localparam logic [4:0] ST_IDLE      = 5'd1;
  localparam logic [4:0] ST_DISPATCH  = 5'd2;
  localparam logic [4:0] ST_EDGE_RD   = 5'd3;
  localparam logic [4:0] ST_EDGE_WR   = 5'd4;
  localparam logic [4:0] ST_RB_START  = 5'd5;
  localparam logic [4:0] ST_ROW_RD    = 5'd6;
  localparam logic [4:0] ST_ROW_LD    = 5'd7;
  localparam logic [4:0] ST_SCAN      = 5'd8;
  localparam logic [4:0] ST_ROW_WR    = 5'd9;
  localparam logic [4:0] ST_CNT_START = 5'd10;
  localparam logic [4:0] ST_CNT_RD    = 5'd11;
  localparam logic [4:0] ST_CNT_LD    = 5'd12;
  localparam logic [4:0] ST_CNT_RUN   = 5'd13;
  localparam logic [4:0] ST_QRY_RD    = 5'd14;
  localparam logic [4:0] ST_QRY_LD    = 5'd15;
  localparam logic [4:0] ST_RESULT    = 5'd16;

  logic [4:0]                         state_r, state_nxt;
  logic [AW-1:0]                      clr_r, clr_nxt;
  logic [VW-1:0]                      row_r, row_nxt;
  logic [VW-1:0]                      j_r, j_nxt;
  logic [VW-1:0]                      cnt_row_r, cnt_row_nxt;
  logic                               qbit_r, qbit_nxt;
  logic [dagr_pkg::VERTEX_W-1:0]      vc_r;
  dagr_pkg::in_word_t                 item_r;
  logic                               out_valid_r, out_valid_nxt;
  dagr_pkg::out_word_t                out_data_r, out_data_nxt;

  // Store ports.
  logic          adj_we, reach_we;
  logic [AW-1:0] adj_waddr, adj_raddr, reach_waddr, reach_raddr;
  logic [N-1:0]  adj_wdata, adj_rdata, reach_wdata, reach_rdata;

  // Shared units.
  dagr_pkg::row_or_ctl_t or_ctl;
  dagr_pkg::popcnt_ctl_t pc_ctl;
  logic [N-1:0]          acc_or;
  logic [TW-1:0]         total;
  logic                  pc_last;

  // Decoded item fields, saturated to the vertex range.
  logic [CW-1:0] u_ext, v_ext, vc_ext;
  logic [VW-1:0] u_int, v_int, n_int, rb_start;
  logic          pair_ok;
  logic [AW-1:0] u_idx, v_idx;
  logic          is_query;
  logic [N-1:0]  adj_mod;

  // Final count arithmetic.
  logic [TW-1:0]               n_tw, diff;
  logic [EW-1:0]               diff_ext;
  logic [dagr_pkg::PAIR_W-1:0] pair_count;

  assign u_ext  = CW'(item_r.src_vertex);
  assign v_ext  = CW'(item_r.dst_vertex);
  assign vc_ext = CW'(vc_r);

  assign u_int  = (u_ext > CW'(N)) ? VW'(N) : VW'(u_ext);
  assign v_int  = (v_ext > CW'(N)) ? VW'(N) : VW'(v_ext);
  assign n_int  = (vc_ext > CW'(N)) ? VW'(N) : VW'(vc_ext);

  assign pair_ok = (u_ext != '0) && (u_ext <= CW'(N)) &&
                   (v_ext != '0) && (v_ext <= CW'(N));
  assign u_idx   = AW'(u_int - VW'(1));
  assign v_idx   = AW'(v_int - VW'(1));
  assign is_query = (item_r.opcode == dagr_pkg::OP_QUERY);

  // A full rebuild starts at vertex_count, an edge update at its source row.
  assign rb_start = (item_r.opcode == dagr_pkg::OP_FULL) ? n_int : u_int;

  // Edge update: set or clear one bit of the adjacency row just read.
  always_comb begin
    adj_mod        = adj_rdata;
    adj_mod[v_idx] = (item_r.opcode != dagr_pkg::OP_REMOVE);
  end

  // Pair count: total set bits minus the vertices in use, clamped to 0..PAIR_MAX.
  assign n_tw     = TW'(n_int);
  assign diff     = total - n_tw;
  assign diff_ext = EW'(diff);
  always_comb begin
    if (total <= n_tw) begin
      pair_count = '0;
    end else if (diff_ext > EW'(dagr_pkg::PAIR_MAX)) begin
      pair_count = dagr_pkg::PAIR_MAX;
    end else begin
      pair_count = diff_ext[dagr_pkg::PAIR_W-1:0];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    row_nxt       = row_r;
    j_nxt         = j_r;
    cnt_row_nxt   = cnt_row_r;
    qbit_nxt      = qbit_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    adj_we      = 1'b0;
    adj_waddr   = u_idx;
    adj_wdata   = adj_mod;
    adj_raddr   = u_idx;
    reach_we    = 1'b0;
    reach_waddr = AW'(row_r - VW'(1));
    reach_wdata = acc_or | (N'(1) << AW'(row_r - VW'(1)));
    reach_raddr = u_idx;

    or_ctl = '0;
    pc_ctl = '0;
    or_ctl.self_j = (j_r == row_r);

    unique case (state_r)
      ST_CLEAR: begin
        adj_we      = 1'b1;
        adj_waddr   = clr_r;
        adj_wdata   = '0;
        reach_we    = 1'b1;
        reach_waddr = clr_r;
        reach_wdata = '0;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (item_r.opcode)
          dagr_pkg::OP_LOAD: begin
            state_nxt = pair_ok ? ST_EDGE_RD : ST_IDLE;
          end
          dagr_pkg::OP_ADD, dagr_pkg::OP_REMOVE: begin
            state_nxt = pair_ok ? ST_EDGE_RD : ST_RB_START;
          end
          dagr_pkg::OP_QUERY: begin
            state_nxt = ST_QRY_RD;
          end
          dagr_pkg::OP_FULL: begin
            state_nxt = ST_RB_START;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EDGE_RD: begin
        adj_raddr = u_idx;
        state_nxt = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        adj_we    = 1'b1;
        state_nxt = (item_r.opcode == dagr_pkg::OP_LOAD) ? ST_IDLE : ST_RB_START;
      end
      ST_RB_START: begin
        row_nxt   = rb_start;
        state_nxt = (rb_start == '0) ? ST_CNT_START : ST_ROW_RD;
      end
      ST_ROW_RD: begin
        adj_raddr = AW'(row_r - VW'(1));
        state_nxt = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        or_ctl.load = 1'b1;
        j_nxt       = VW'(1);
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue the read of reach row j; the OR of the previous read lands now.
        reach_raddr = AW'(j_r - VW'(1));
        or_ctl.step = 1'b1;
        j_nxt       = j_r + VW'(1);
        if (j_r == VW'(N)) begin
          state_nxt = ST_ROW_WR;
        end
      end
      ST_ROW_WR: begin
        reach_we = 1'b1;
        row_nxt  = row_r - VW'(1);
        state_nxt = (row_r == VW'(1)) ? ST_CNT_START : ST_ROW_RD;
      end
      ST_CNT_START: begin
        pc_ctl.clear_total = 1'b1;
        cnt_row_nxt        = VW'(1);
        state_nxt          = (n_int == '0) ? ST_RESULT : ST_CNT_RD;
      end
      ST_CNT_RD: begin
        reach_raddr = AW'(cnt_row_r - VW'(1));
        state_nxt   = ST_CNT_LD;
      end
      ST_CNT_LD: begin
        pc_ctl.load = 1'b1;
        state_nxt   = ST_CNT_RUN;
      end
      ST_CNT_RUN: begin
        pc_ctl.step = 1'b1;
        if (pc_last) begin
          cnt_row_nxt = cnt_row_r + VW'(1);
          state_nxt   = (cnt_row_r == n_int) ? ST_RESULT : ST_CNT_RD;
        end
      end
      ST_QRY_RD: begin
        reach_raddr = u_idx;
        state_nxt   = ST_QRY_LD;
      end
      ST_QRY_LD: begin
        qbit_nxt  = pair_ok & reach_rdata[v_idx];
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // Hand the result over once the output register is free or draining.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.answer_kind = is_query;
          out_data_nxt.reachable   = is_query & qbit_r;
          out_data_nxt.pair_count  = is_query ? '0 : pair_count;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vc_r        <= dagr_pkg::VC_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        vc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    j_r        <= j_nxt;
    cnt_row_r  <= cnt_row_nxt;
    qbit_r     <= qbit_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
  end

  dagr_ram #(
    .Width (N),
    .Depth (N)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dagr_ram #(
    .Width (N),
    .Depth (N)
  ) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  dagr_row_or #(
    .Width (N)
  ) u_row_or (
    .clk      (clk),
    .ctl      (or_ctl),
    .adj_row  (adj_rdata),
    .reach_rd (reach_rdata),
    .acc_or   (acc_or)
  );

  dagr_popcnt #(
    .Width (N)
  ) u_popcnt (
    .clk   (clk),
    .ctl   (pc_ctl),
    .row   (reach_rdata),
    .total (total),
    .last  (pc_last)
  );

endmodule

`default_nettype wire

### verif/dagr_closure_monitor.sv
// Monitor that predicts the reachability engine's answers and checks every returned word.
module dagr_closure_monitor
  import dagr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_word_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_word_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [VERTEX_W-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  answers_due
);

  localparam int NV = MAX_VERTICES_DEF;

  // Row i bit j set means edge i->j (adjacency) or j reachable from i (reach).
  bit [NV:0]           model_adjacency [0:NV];
  bit [NV:0]           model_reach     [0:NV];
  logic [VERTEX_W-1:0] model_vertex_count;
  out_word_t           predicted_answers [$];

  function automatic int clamp_vertex(input logic [VERTEX_W-1:0] v);
    return (v > NV) ? NV : int'(v);
  endfunction

  function automatic bit vertex_ok(input logic [VERTEX_W-1:0] v);
    return (v >= 1) && (v <= NV);
  endfunction

  // Rebuilds reach rows from start down to 1, then counts pairs over the rows in use.
  function automatic logic [PAIR_W-1:0] rebuild_pair_count(input int start);
    bit [NV:0] acc;
    int        total;
    int        rows;
    for (int i = start; i >= 1; i--) begin
      acc = '0;
      // A self loop ORs the row into itself while it is being built, which adds nothing.
      for (int j = 1; j <= NV; j++)
        if (model_adjacency[i][j] && j != i) acc |= model_reach[j];
      acc[i] = 1'b1;
      model_reach[i] = acc;
    end
    rows  = clamp_vertex(model_vertex_count);
    total = 0;
    for (int i = 1; i <= rows; i++) total += $countones(model_reach[i]);
    if (total <= rows) return '0;
    total -= rows;
    return (total > int'(PAIR_MAX)) ? PAIR_MAX : PAIR_W'(total);
  endfunction

  task automatic predict_word(input in_word_t w);
    out_word_t answer;
    bit        ok;
    ok     = vertex_ok(w.src_vertex) && vertex_ok(w.dst_vertex);
    answer = '0;
    case (w.opcode)
      OP_LOAD, OP_ADD, OP_REMOVE: begin
        if (ok) model_adjacency[w.src_vertex][w.dst_vertex] = (w.opcode != OP_REMOVE);
        if (w.opcode != OP_LOAD) begin
          answer.pair_count = rebuild_pair_count(clamp_vertex(w.src_vertex));
          predicted_answers.push_back(answer);
        end
      end
      OP_QUERY: begin
        answer.answer_kind = 1'b1;
        if (ok) answer.reachable = model_reach[w.src_vertex][w.dst_vertex];
        predicted_answers.push_back(answer);
      end
      OP_FULL: begin
        answer.pair_count = rebuild_pair_count(clamp_vertex(model_vertex_count));
        predicted_answers.push_back(answer);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [PAIR_W-1:0] want,
                             input logic [PAIR_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      model_adjacency    = '{default: '0};
      model_reach        = '{default: '0};
      model_vertex_count = VC_RESET;
      predicted_answers.delete();
    end else begin
      // Results are matched before new words are predicted, so order is kept.
      if (out_valid && !out_stall) begin
        if (predicted_answers.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, actual kind %0h reach %0h count %0h",
                   $time, out_data.answer_kind, out_data.reachable, out_data.pair_count);
        end else begin
          want = predicted_answers.pop_front();
          check_field("answer_kind", PAIR_W'(want.answer_kind),
                      PAIR_W'(out_data.answer_kind));
          check_field("reachable", PAIR_W'(want.reachable), PAIR_W'(out_data.reachable));
          check_field("pair_count", want.pair_count, out_data.pair_count);
        end
      end
      if (cfg_valid && cfg_ready) model_vertex_count = cfg_data;
      if (in_valid && !in_stall) predict_word(in_data);
    end
    answers_due = predicted_answers.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top for the DAG reachability engine: clock, reset, stimulus and verdict.
module tb_top;
  import dagr_pkg::*;

  // Opcodes above OP_FULL are not decoded by the engine and must be dropped.
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  // Words per random phase, counting only words that the engine acts on.
  localparam int PHASE_WORDS    = 15;
  localparam int RANDOM_PHASES  = 4;
  // Long receiver hold-off used to back the engine up into its input.
  localparam int LONG_HOLD      = 300;
  // Cycles allowed after the last answer for a silent edge load to finish.
  localparam int SETTLE_CYCLES  = 50;
  // The slowest single word is a full rebuild of 256 rows plus a count of 256 rows,
  // with nothing accepted meanwhile.
  localparam int WATCHDOG_LIMIT = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [VERTEX_W-1:0] cfg_data;

  int mismatch_count;
  int answers_due;

  // Set in the last part of the run: neither side idles any more.
  bit quiet;
  // Each increment asks the receiver for one long hold-off.
  int hold_ticket;

  dag_reachability_bitset_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dagr_closure_monitor i_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .answers_due    (answers_due)
  );

  always #5 clk = ~clk;

  // Offers one word at a falling edge and holds it until it is taken. Valid stays
  // high on return, so a following word goes out back to back; every path that
  // stops sending lowers valid itself.
  task automatic send_word(input in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_item(input logic [OPCODE_W-1:0] op, input int src, input int dst);
    in_word_t w;
    w.opcode     = op;
    w.src_vertex = VERTEX_W'(src);
    w.dst_vertex = VERTEX_W'(dst);
    send_word(w);
  endtask

  // Stops offering words and waits until every predicted answer has come back.
  task automatic wait_answers_in();
    in_valid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
  endtask

  // The register is only written while the engine is idle. A silent edge load may
  // still be in flight after the last answer, hence the settling pause.
  task automatic program_vertex_count(input int value);
    wait_answers_in();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= VERTEX_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random word over vertices 1..span. Most words are edges, mostly pointing forward,
  // rebuilds from small rows and in-range queries; a few carry any 9-bit vertex or an
  // opcode the engine ignores. Rebuild starts stay small, since a rebuild walks all
  // 256 columns of every row it builds.
  function automatic in_word_t random_word(input int span);
    in_word_t            w;
    int                  pick;
    logic [VERTEX_W-1:0] swap;
    pick         = $urandom_range(0, 99);
    w.src_vertex = VERTEX_W'($urandom_range(1, span));
    w.dst_vertex = VERTEX_W'($urandom_range(1, span));
    if (w.src_vertex > w.dst_vertex && $urandom_range(0, 3) != 0) begin
      swap         = w.src_vertex;
      w.src_vertex = w.dst_vertex;
      w.dst_vertex = swap;
    end
    if (pick < 35) w.opcode = OP_LOAD;
    else if (pick < 50) w.opcode = OP_ADD;
    else if (pick < 58) w.opcode = OP_REMOVE;
    else if (pick < 82) w.opcode = OP_QUERY;
    else if (pick < 88) w.opcode = OP_FULL;
    else begin
      // Noise: cheap opcodes with arbitrary vertex fields, or undecoded opcodes.
      w.opcode     = (pick < 96) ? (($urandom_range(0, 1) == 1) ? OP_QUERY : OP_LOAD)
                                 : OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      w.src_vertex = VERTEX_W'($urandom());
      w.dst_vertex = VERTEX_W'($urandom());
    end
    return w;
  endfunction

  // Receiver: random stall bursts with free-running stretches in between, one long
  // hold-off per ticket, and no stalls at all once the run goes quiet.
  initial begin : receiver
    int seen;
    seen      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (hold_ticket != seen) begin
        seen = hold_ticket;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no channel has moved a word for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    in_word_t w;
    int       counted;
    int       vc_now;
    int       span;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    quiet       = 1'b0;
    hold_ticket = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with vertex_count still at its reset value of 256. The engine
    // runs its clearing pass first; the handshake simply waits for it.
    // Two silent loads, then an add rebuilds rows 3..1. Row 4 was never built, so
    // vertex 1 reaches 3 but not 4 yet, and most rows lack their own bit, which
    // drives the count below vertex_count and saturates it at zero.
    send_item(OP_LOAD, 1, 2);
    send_item(OP_LOAD, 2, 3);
    send_item(OP_ADD, 3, 4);
    send_item(OP_QUERY, 1, 3);
    send_item(OP_QUERY, 1, 4);
    // A full rebuild over all 256 rows fixes the chain and sets every own bit.
    send_item(OP_FULL, 0, 511);
    send_item(OP_QUERY, 1, 4);
    send_item(OP_QUERY, 256, 256);
    // Queries with a vertex of zero or beyond the matrix answer unreachable.
    send_item(OP_QUERY, 0, 1);
    send_item(OP_QUERY, 511, 256);
    // Edge writes with a vertex out of range are dropped.
    send_item(OP_LOAD, 0, 5);
    send_item(OP_LOAD, 5, 0);
    send_item(OP_LOAD, 300, 1);
    // Undecoded opcodes give no answer.
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_item(OPCODE_W'(op), $urandom_range(0, 511), $urandom_range(0, 511));
    // An add with source zero writes nothing and rebuilds no rows, yet reports.
    send_item(OP_ADD, 0, 5);
    send_item(OP_REMOVE, 2, 3);
    // A self loop must not pull the row's stale contents into its own rebuild.
    send_item(OP_LOAD, 5, 5);
    send_item(OP_ADD, 5, 6);
    send_item(OP_QUERY, 5, 5);
    send_item(OP_LOAD, 256, 1);
    // A rebuild start beyond the matrix saturates to the last row.
    send_item(OP_ADD, 511, 1);
    send_item(OP_REMOVE, 0, 0);

    // vertex_count of zero counts no rows; a full rebuild then touches nothing.
    program_vertex_count(0);
    send_item(OP_FULL, 3, 3);
    send_item(OP_ADD, 1, 2);
    send_item(OP_QUERY, 1, 2);

    // A value beyond the matrix saturates, both as full rebuild start and as row count.
    program_vertex_count(511);
    send_item(OP_FULL, 1, 1);
    send_item(OP_QUERY, 256, 1);

    program_vertex_count(1);
    send_item(OP_ADD, 1, 3);
    send_item(OP_FULL, 2, 2);
    send_item(OP_QUERY, 1, 3);

    // Random phases with small vertex counts keep each rebuild short.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       vc_now = 3;
        1:       vc_now = 12;
        2:       vc_now = $urandom_range(2, 24);
        default: vc_now = 20;
      endcase
      span    = vc_now + 2;
      counted = 0;
      quiet   = (phase == RANDOM_PHASES - 1);
      program_vertex_count(vc_now);
      if (phase == 1) begin
        // The receiver holds off while quick queries keep coming, so the engine's
        // output register fills, the next query waits inside, and in_stall stays up.
        hold_ticket++;
        repeat (6) begin
          send_item(OP_QUERY, $urandom_range(1, span), $urandom_range(1, span));
          counted++;
        end
      end
      while (counted < PHASE_WORDS) begin
        w = random_word(span);
        send_word(w);
        if (w.opcode <= OP_FULL) begin
          counted++;
          // Once per run the sender stops until every answer is back.
          if (phase == 2 && counted == 10) wait_answers_in();
        end
      end
    end

    // The largest legal setting, written explicitly, with one short rebuild.
    program_vertex_count(256);
    send_item(OP_QUERY, 2, 3);
    send_item(OP_REMOVE, 1, 2);

    wait_answers_in();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && answers_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
